@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
// each macro expects signals clk and rst_n in the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slfr_pkg.sv @@
// shared constants and types for the length-prefixed frame receiver
// no dependencies
package slfr_pkg;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HUNT    = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_LEN_LO  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_BYTE    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_MARKER  = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  localparam logic [7:0]  SYNC_BYTE     = 8'h5A;
  localparam logic [7:0]  START_BYTE    = 8'h58;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_byte;
    logic       last;
  } res_t;

endpackage

@@ rtl/sync_length_frame_receiver.sv @@
// channel   | handshake          | payload
// in_       | in_valid/in_stall  | opcode, rx_byte, capacity
// out_      | out_valid/out_stall| status, data_byte, last
// cfg_      | cfg_we             | cfg_wdata (timeout ticks)
// one request in per cycle while in_stall is low; its result is registered
// every request gives exactly one result, an arm included
// in_stall rises only when both the result register and the skid entry are full
// synchronous active-low reset; timeout returns to 500 ticks
// top level: state machine plus result buffer; depends on slfr_pkg, slfr_fsm, slfr_skid
module sync_length_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);

  logic           in_acc;
  logic           full;
  slfr_pkg::res_t res;
  slfr_pkg::res_t out_res;

  assign in_stall = full;
  assign in_acc   = in_valid && !full;

  slfr_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (in_acc),
    .opcode    (in_opcode),
    .rx_byte   (in_rx_byte),
    .capacity  (in_capacity),
    .res       (res)
  );

  slfr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status    = out_res.status;
  assign out_data_byte = out_res.data_byte;
  assign out_last      = out_res.last;

endmodule

@@ rtl/slfr_fsm.sv @@
// receive state machine: header hunt, length check, payload count, tick timeout
// depends on slfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module slfr_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              acc,
  input  logic [1:0]        opcode,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       capacity,
  output slfr_pkg::res_t    res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] bleft_r, bleft_nxt;
  logic [15:0] limit_r, limit_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] tmo_r;
  logic [15:0] len_full;
  logic [16:0] tick_sum;

  assign len_full = {flen_r[15:8], rx_byte};
  assign tick_sum = {1'b0, ticks_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    bleft_nxt = bleft_r;
    limit_nxt = limit_r;
    ticks_nxt = ticks_r;
    res       = '0;
    if (acc) begin
      unique case (opcode)
        slfr_pkg::OP_ARM: begin
          limit_nxt = capacity;
          flen_nxt  = '0;
          bleft_nxt = '0;
          ticks_nxt = '0;
          phase_nxt = slfr_pkg::PH_HUNT;
        end
        slfr_pkg::OP_BYTE: begin
          if (phase_r != slfr_pkg::PH_IDLE) begin
            ticks_nxt = '0;
            unique case (phase_r)
              slfr_pkg::PH_HUNT: begin
                if (rx_byte == slfr_pkg::SYNC_BYTE) phase_nxt = slfr_pkg::PH_SKIP;
              end
              slfr_pkg::PH_SKIP: begin
                if (rx_byte == slfr_pkg::START_BYTE) begin
                  phase_nxt = slfr_pkg::PH_LEN_HI;
                end else if (rx_byte != slfr_pkg::SYNC_BYTE) begin
                  phase_nxt  = slfr_pkg::PH_IDLE;
                  bleft_nxt  = '0;
                  res.status = slfr_pkg::ST_MARKER;
                end
              end
              slfr_pkg::PH_LEN_HI: begin
                flen_nxt  = {rx_byte, 8'h00};
                phase_nxt = slfr_pkg::PH_LEN_LO;
              end
              slfr_pkg::PH_LEN_LO: begin
                flen_nxt = len_full;
                if (len_full > limit_r) begin
                  phase_nxt  = slfr_pkg::PH_IDLE;
                  bleft_nxt  = '0;
                  res.status = slfr_pkg::ST_LONG;
                end else if (len_full == 16'd0) begin
                  phase_nxt  = slfr_pkg::PH_IDLE;
                  bleft_nxt  = '0;
                  res.status = slfr_pkg::ST_EMPTY;
                end else begin
                  bleft_nxt = len_full;
                  phase_nxt = slfr_pkg::PH_PAYLOAD;
                end
              end
              slfr_pkg::PH_PAYLOAD: begin
                res.status    = slfr_pkg::ST_BYTE;
                res.data_byte = rx_byte;
                if (bleft_r <= 16'd1) begin
                  res.last  = 1'b1;
                  phase_nxt = slfr_pkg::PH_IDLE;
                  bleft_nxt = '0;
                end else begin
                  bleft_nxt = bleft_r - 16'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        slfr_pkg::OP_TICK: begin
          if (phase_r != slfr_pkg::PH_IDLE) begin
            if (tick_sum > {1'b0, tmo_r}) begin
              phase_nxt  = slfr_pkg::PH_IDLE;
              bleft_nxt  = '0;
              ticks_nxt  = '0;
              res.status = slfr_pkg::ST_TIMEOUT;
            end else begin
              ticks_nxt = tick_sum[15:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slfr_pkg::PH_IDLE;
      flen_r  <= '0;
      bleft_r <= '0;
      limit_r <= '0;
      ticks_r <= '0;
      tmo_r   <= slfr_pkg::TIMEOUT_RESET;
    end else begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      bleft_r <= bleft_nxt;
      limit_r <= limit_nxt;
      ticks_r <= ticks_nxt;
      if (cfg_we) tmo_r <= cfg_wdata;
    end
  end

  `ASSERT_IMPL(a_payload_nonzero, phase_r == slfr_pkg::PH_PAYLOAD, bleft_r != 16'd0, "payload phase with no bytes left")
  `ASSERT_IMPL(a_payload_in_limit, phase_r == slfr_pkg::PH_PAYLOAD, bleft_r <= limit_r, "payload count above capacity")
  `ASSERT_IMPL(a_idle_no_ticks, phase_r == slfr_pkg::PH_IDLE, ticks_r == 16'd0, "tick count held while idle")

endmodule

@@ rtl/slfr_skid.sv @@
// result register with one skid entry so the input stall is registered
// depends on slfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module slfr_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  slfr_pkg::res_t    res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output slfr_pkg::res_t    out_res
);

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  slfr_pkg::res_t out_res_r, out_res_nxt;
  slfr_pkg::res_t skid_res_r, skid_res_nxt;
  logic           out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      out_res_nxt    = skid_valid_r ? skid_res_r : res;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry without result entry")
  `ASSERT_IMPL(a_no_overflow, skid_valid_r, !in_acc, "request accepted with skid full")
  `ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r, "skid entry not moved forward")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for sync_length_frame_receiver: driver and monitor
// processes around an in-line deframing predictor; depends on slfr_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [15:0] capacity;
  } deframe_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [15:0] in_capacity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte;
  logic        out_last;

  sync_length_frame_receiver dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_rx_byte   (in_rx_byte),
    .in_capacity  (in_capacity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_byte(out_data_byte),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  ph = slfr_pkg::PH_IDLE;
  logic [15:0] frm_len = '0;
  logic [15:0] left = '0;
  logic [15:0] lim = '0;
  logic [15:0] ticks = '0;
  logic [15:0] tmo = slfr_pkg::TIMEOUT_RESET;

  deframe_req_t    req_q[$];
  slfr_pkg::res_t  due_results[$];
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  logic            hold_go = 1'b0;
  int              hold_left = 0;
  int              n_err = 0;
  int              n_sent = 0;
  int              n_got = 0;
  int              n_cfg = 0;
  int              seen[8];

  function automatic void go_quiet();
    ph = slfr_pkg::PH_IDLE;
    left = '0;
    ticks = '0;
  endfunction

  function automatic slfr_pkg::res_t deframe_step(logic [1:0] op, logic [7:0] b,
                                                  logic [15:0] cap);
    slfr_pkg::res_t r;
    logic [16:0]    nxt;
    r = '0;
    case (op)
      slfr_pkg::OP_ARM: begin
        lim = cap;
        frm_len = '0;
        left = '0;
        ticks = '0;
        ph = slfr_pkg::PH_HUNT;
      end
      slfr_pkg::OP_BYTE: if (ph != slfr_pkg::PH_IDLE) begin
        ticks = '0;
        case (ph)
          slfr_pkg::PH_HUNT: if (b == slfr_pkg::SYNC_BYTE) ph = slfr_pkg::PH_SKIP;
          slfr_pkg::PH_SKIP: begin
            if (b == slfr_pkg::START_BYTE) begin
              ph = slfr_pkg::PH_LEN_HI;
            end else if (b != slfr_pkg::SYNC_BYTE) begin
              go_quiet();
              r.status = slfr_pkg::ST_MARKER;
            end
          end
          slfr_pkg::PH_LEN_HI: begin
            frm_len = {b, 8'h00};
            ph = slfr_pkg::PH_LEN_LO;
          end
          slfr_pkg::PH_LEN_LO: begin
            frm_len[7:0] = b;
            if (frm_len > lim) begin
              go_quiet();
              r.status = slfr_pkg::ST_LONG;
            end else if (frm_len == 16'd0) begin
              go_quiet();
              r.status = slfr_pkg::ST_EMPTY;
            end else begin
              left = frm_len;
              ph = slfr_pkg::PH_PAYLOAD;
            end
          end
          slfr_pkg::PH_PAYLOAD: begin
            r.status = slfr_pkg::ST_BYTE;
            r.data_byte = b;
            if (left <= 16'd1) begin
              r.last = 1'b1;
              go_quiet();
            end else begin
              left = left - 16'd1;
            end
          end
          default: ;
        endcase
      end
      slfr_pkg::OP_TICK: if (ph != slfr_pkg::PH_IDLE) begin
        nxt = {1'b0, ticks} + 17'd1;
        if (nxt > {1'b0, tmo}) begin
          go_quiet();
          r.status = slfr_pkg::ST_TIMEOUT;
        end else begin
          ticks = nxt[15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: one request presented at a time, held while stalled
  always @(posedge clk) begin : drive
    deframe_req_t nr;
    logic         have;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      have = in_valid;
      if (in_valid && !in_stall) begin
        due_results.push_back(deframe_step(in_opcode, in_rx_byte, in_capacity));
        n_sent++;
        have = 1'b0;
      end
      if (!have && req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nr = req_q.pop_front();
        in_opcode <= nr.op;
        in_rx_byte <= nr.rx_byte;
        in_capacity <= nr.capacity;
        have = 1'b1;
      end
      in_valid <= have;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    slfr_pkg::res_t got;
    slfr_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status: out_status, data_byte: out_data_byte, last: out_last};
        n_got++;
        seen[got.status]++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result status %0d data %02h last %0b",
                   $realtime, got.status, got.data_byte, got.last);
          n_err++;
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, want.status, got.status);
            n_err++;
          end
          if (got.data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %02h actual %02h",
                     $realtime, want.data_byte, got.data_byte);
            n_err++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $realtime, want.last, got.last);
            n_err++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] b, logic [15:0] cap,
                           ref int made);
    deframe_req_t r;
    r.op = op;
    r.rx_byte = (op == slfr_pkg::OP_BYTE) ? b : 8'($urandom);
    r.capacity = (op == slfr_pkg::OP_ARM) ? cap : 16'($urandom);
    req_q.push_back(r);
    made++;
  endtask

  task automatic push_gap(ref int made);
    int k;
    if ($urandom_range(99) < 15) begin
      k = $urandom_range(1, 2);
      repeat (k) push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, made);
    end
  endtask

  // kind: -1 well formed, 0 bad marker, 1 ticks toward a timeout, 2 cut short, 3 trailing idle bytes
  task automatic push_frame(int kind, ref int made);
    int         len;
    int         cap;
    int         r;
    int         n;
    logic [7:0] b;
    len = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
    r = $urandom_range(9);
    if (r == 0) begin
      cap = 0;
    end else if (r == 1) begin
      cap = 65535;
    end else if (r == 2 && len > 0) begin
      cap = len - 1;
    end else begin
      cap = len + $urandom_range(0, 3);
      if (cap > 65535) cap = 65535;
    end
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'(cap), made);
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_gap(made);
      b = 8'($urandom);
      if (b == slfr_pkg::SYNC_BYTE) b = 8'h00;
      push_item(slfr_pkg::OP_BYTE, b, 16'h0000, made);
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      push_gap(made);
      push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, made);
    end
    push_gap(made);
    if (kind == 0) begin
      b = 8'($urandom);
      if (b == slfr_pkg::START_BYTE || b == slfr_pkg::SYNC_BYTE) b = 8'hFF;
      push_item(slfr_pkg::OP_BYTE, b, 16'h0000, made);
      return;
    end
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::START_BYTE, 16'h0000, made);
    if (kind == 1) begin
      n = (tmo <= 16'd64) ? $urandom_range(int'(tmo), int'(tmo) + 1) : 2;
      repeat (n) push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, made);
      return;
    end
    push_gap(made);
    push_item(slfr_pkg::OP_BYTE, 8'(len >> 8), 16'h0000, made);
    push_gap(made);
    push_item(slfr_pkg::OP_BYTE, 8'(len), 16'h0000, made);
    n = (len > 20) ? 20 : len;
    if (kind == 2) n = $urandom_range(0, n);
    repeat (n) begin
      push_gap(made);
      push_item(slfr_pkg::OP_BYTE, 8'($urandom), 16'h0000, made);
    end
    if (kind == 3) begin
      push_item(slfr_pkg::OP_BYTE, 8'($urandom), 16'h0000, made);
      push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, made);
    end
  endtask

  task automatic gen_random(int count);
    int made;
    int r;
    int junk;
    logic [1:0] op;
    made = 0;
    junk = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 68) begin
        push_frame(-1, made);
      end else if (r < 88) begin
        push_frame($urandom_range(0, 3), made);
      end else begin
        r = $urandom_range(2);
        op = (r == 0) ? slfr_pkg::OP_BYTE : (r == 1) ? slfr_pkg::OP_TICK : OP_UNUSED;
        push_item(op, 8'($urandom), 16'($urandom), junk);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || due_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timeout(logic [15:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tmo = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    @(negedge clk);
  endtask

  initial begin
    int d;
    d = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // ignored requests while idle
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'hFF, 16'h0000, d);
    push_item(OP_UNUSED, 8'hFF, 16'hFFFF, d);
    // empty frame, capacity zero, discard in hunt, repeated sync
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::START_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h00, 16'h0000, d);
    // two payload bytes at full capacity, a tick in between
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'hFFFF, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::START_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h02, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'hFF, 16'h0000, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h00, 16'h0000, d);
    // too long
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0001, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::START_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'hFF, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'hFF, 16'h0000, d);
    // re-arm while active, then bad marker
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0005, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0002, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, 8'h41, 16'h0000, d);

    // timeout register zero: first tick times out
    set_timeout(16'd0);
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0004, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    set_timeout(16'd2);
    push_item(slfr_pkg::OP_ARM, 8'h00, 16'h0004, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_BYTE, slfr_pkg::SYNC_BYTE, 16'h0000, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);
    push_item(slfr_pkg::OP_TICK, 8'h00, 16'h0000, d);

    // sender idles rarely, receiver often
    set_timeout(16'd1);
    send_idle_pct = 16;
    recv_idle_pct = 84;
    gen_random(270);
    set_timeout(16'hFFFF);
    gen_random(270);

    // the other way round
    set_timeout(16'd3);
    send_idle_pct = 84;
    recv_idle_pct = 16;
    gen_random(270);
    set_timeout(16'd200);
    gen_random(270);

    // no idling
    set_timeout(16'($urandom_range(1, 40)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(270);

    // receiver holds off while requests keep coming
    wait_drained();
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    @(negedge clk);
    gen_random(60);

    set_timeout(slfr_pkg::TIMEOUT_RESET);
    gen_random(270);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("%0d requests, %0d results, %0d timeout writes", n_sent, n_got, n_cfg);
    $display("payload %0d, empty %0d, bad marker %0d, too long %0d, timeout %0d",
             seen[slfr_pkg::ST_BYTE], seen[slfr_pkg::ST_EMPTY], seen[slfr_pkg::ST_MARKER],
             seen[slfr_pkg::ST_LONG], seen[slfr_pkg::ST_TIMEOUT]);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still due", $realtime, due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
